// ===== src/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants of the segment intersection test pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

    // Default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // Segment tests run in parallel: lane 0 is the second segment or the
    // left box edge, lanes 1 to 3 are the remaining box edges.
    localparam int NUM_LANES = 4;

    // Coordinates of a segment: start x, start y, end x, end y
    localparam int NUM_COORD = 4;
    localparam int IX_AX     = 0;
    localparam int IX_AY     = 1;
    localparam int IX_BX     = 2;
    localparam int IX_BY     = 3;

    // Each lane forms four cross products, each the difference of two products
    localparam int NUM_CROSS = 4;
    localparam int NUM_PROD  = 2 * NUM_CROSS;

    // Query command
    typedef enum logic [1:0] {
        CMD_INTERSECTS = 2'd0,
        CMD_TOUCHES    = 2'd1,
        CMD_SHARES     = 2'd2,
        CMD_BOX        = 2'd3
    } cmd_t;

    // Outcome of one segment-against-segment test
    typedef enum logic [1:0] {
        SEG_NONE    = 2'd0,
        SEG_CROSS   = 2'd1,
        SEG_CONTACT = 2'd2
    } seg_res_t;

    // Per-item control that rides along with the lane data
    typedef struct packed {
        cmd_t cmd;
        logic share;
        logic inbox;
    } ctl_t;

endpackage

// ===== src/sit_front.sv =====
// ----------------------------------------------------------------------------
// sit_front
// First two pipeline stages: box corners, lane operand selection, endpoint
// and containment checks, bounding box overlap and cross product operands.
// ----------------------------------------------------------------------------
module sit_front #(
    parameter int W = sit_pkg::COORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [1:0]           command,
    input  logic signed [W-1:0]  seg_a_x,
    input  logic signed [W-1:0]  seg_a_y,
    input  logic signed [W-1:0]  seg_b_x,
    input  logic signed [W-1:0]  seg_b_y,
    input  logic signed [W-1:0]  other_a_x,
    input  logic signed [W-1:0]  other_a_y,
    input  logic signed [W-1:0]  other_b_x,
    input  logic signed [W-1:0]  other_b_y,
    output logic signed [W:0]    ma [sit_pkg::NUM_LANES][sit_pkg::NUM_PROD],
    output logic signed [W:0]    mb [sit_pkg::NUM_LANES][sit_pkg::NUM_PROD],
    output logic                 ovl [sit_pkg::NUM_LANES],
    output sit_pkg::ctl_t        ctl
);

    // Stage 1 registers
    logic signed [W-1:0] s_reg [sit_pkg::NUM_COORD];
    logic signed [W-1:0] t_reg [sit_pkg::NUM_LANES][sit_pkg::NUM_COORD];
    logic signed [W-1:0] t_next [sit_pkg::NUM_LANES][sit_pkg::NUM_COORD];
    logic signed [W-1:0] box_reg [sit_pkg::NUM_COORD];
    sit_pkg::cmd_t       cmd_reg;
    logic                share_reg;
    logic                share_next;

    // Stage 2 registers
    logic signed [W:0]   ma_reg [sit_pkg::NUM_LANES][sit_pkg::NUM_PROD];
    logic signed [W:0]   ma_next [sit_pkg::NUM_LANES][sit_pkg::NUM_PROD];
    logic signed [W:0]   mb_reg [sit_pkg::NUM_LANES][sit_pkg::NUM_PROD];
    logic signed [W:0]   mb_next [sit_pkg::NUM_LANES][sit_pkg::NUM_PROD];
    logic                ovl_reg [sit_pkg::NUM_LANES];
    logic                ovl_next [sit_pkg::NUM_LANES];
    sit_pkg::ctl_t       ctl_reg;
    sit_pkg::ctl_t       ctl_next;

    // Box bounds, min and max per axis
    logic signed [W-1:0] x0, x1, y0, y1;

    // Exact difference, one bit wider than the coordinates
    function automatic logic signed [W:0] dif(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
        dif = $signed({a[W-1], a}) - $signed({b[W-1], b});
    endfunction

    // Stage 1: box corners and lane operands
    always_comb
    begin
        x0 = (other_a_x < other_b_x) ? other_a_x : other_b_x;
        x1 = (other_a_x < other_b_x) ? other_b_x : other_a_x;
        y0 = (other_a_y < other_b_y) ? other_a_y : other_b_y;
        y1 = (other_a_y < other_b_y) ? other_b_y : other_a_y;

        // lane 0: second segment, or left edge for a box query
        if (sit_pkg::cmd_t'(command) == sit_pkg::CMD_BOX)
        begin
            t_next[0][sit_pkg::IX_AX] = x0;
            t_next[0][sit_pkg::IX_AY] = y0;
            t_next[0][sit_pkg::IX_BX] = x0;
            t_next[0][sit_pkg::IX_BY] = y1;
        end
        else
        begin
            t_next[0][sit_pkg::IX_AX] = other_a_x;
            t_next[0][sit_pkg::IX_AY] = other_a_y;
            t_next[0][sit_pkg::IX_BX] = other_b_x;
            t_next[0][sit_pkg::IX_BY] = other_b_y;
        end
        // bottom edge
        t_next[1][sit_pkg::IX_AX] = x0;
        t_next[1][sit_pkg::IX_AY] = y0;
        t_next[1][sit_pkg::IX_BX] = x1;
        t_next[1][sit_pkg::IX_BY] = y0;
        // right edge
        t_next[2][sit_pkg::IX_AX] = x1;
        t_next[2][sit_pkg::IX_AY] = y0;
        t_next[2][sit_pkg::IX_BX] = x1;
        t_next[2][sit_pkg::IX_BY] = y1;
        // top edge
        t_next[3][sit_pkg::IX_AX] = x0;
        t_next[3][sit_pkg::IX_AY] = y1;
        t_next[3][sit_pkg::IX_BX] = x1;
        t_next[3][sit_pkg::IX_BY] = y1;

        // shared endpoint check
        share_next = (seg_a_x == other_a_x && seg_a_y == other_a_y) ||
                     (seg_a_x == other_b_x && seg_a_y == other_b_y) ||
                     (seg_b_x == other_a_x && seg_b_y == other_a_y) ||
                     (seg_b_x == other_b_x && seg_b_y == other_b_y);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[sit_pkg::IX_AX]   <= seg_a_x;
            s_reg[sit_pkg::IX_AY]   <= seg_a_y;
            s_reg[sit_pkg::IX_BX]   <= seg_b_x;
            s_reg[sit_pkg::IX_BY]   <= seg_b_y;
            box_reg[sit_pkg::IX_AX] <= x0;
            box_reg[sit_pkg::IX_AY] <= y0;
            box_reg[sit_pkg::IX_BX] <= x1;
            box_reg[sit_pkg::IX_BY] <= y1;
            cmd_reg                 <= sit_pkg::cmd_t'(command);
            share_reg               <= share_next;
            for (int l = 0; l < sit_pkg::NUM_LANES; l++)
            begin
                for (int c = 0; c < sit_pkg::NUM_COORD; c++)
                begin
                    t_reg[l][c] <= t_next[l][c];
                end
            end
        end
    end

    // Stage 2: overlap prefilter, containment and cross product operands
    always_comb
    begin
        for (int l = 0; l < sit_pkg::NUM_LANES; l++)
        begin
            logic signed [W-1:0] sxl, sxh, syl, syh, txl, txh, tyl, tyh;
            sxl = (s_reg[0] < s_reg[2]) ? s_reg[0] : s_reg[2];
            sxh = (s_reg[0] < s_reg[2]) ? s_reg[2] : s_reg[0];
            syl = (s_reg[1] < s_reg[3]) ? s_reg[1] : s_reg[3];
            syh = (s_reg[1] < s_reg[3]) ? s_reg[3] : s_reg[1];
            txl = (t_reg[l][0] < t_reg[l][2]) ? t_reg[l][0] : t_reg[l][2];
            txh = (t_reg[l][0] < t_reg[l][2]) ? t_reg[l][2] : t_reg[l][0];
            tyl = (t_reg[l][1] < t_reg[l][3]) ? t_reg[l][1] : t_reg[l][3];
            tyh = (t_reg[l][1] < t_reg[l][3]) ? t_reg[l][3] : t_reg[l][1];
            ovl_next[l] = !(sxl > txh || txl > sxh || syl > tyh || tyl > syh);

            // cross of other endpoints against the first segment
            ma_next[l][0] = dif(t_reg[l][0], s_reg[0]);
            mb_next[l][0] = dif(s_reg[3], s_reg[1]);
            ma_next[l][1] = dif(t_reg[l][1], s_reg[1]);
            mb_next[l][1] = dif(s_reg[2], s_reg[0]);
            ma_next[l][2] = dif(t_reg[l][2], s_reg[0]);
            mb_next[l][2] = dif(s_reg[3], s_reg[1]);
            ma_next[l][3] = dif(t_reg[l][3], s_reg[1]);
            mb_next[l][3] = dif(s_reg[2], s_reg[0]);
            // cross of first segment endpoints against the other line
            ma_next[l][4] = dif(s_reg[0], t_reg[l][0]);
            mb_next[l][4] = dif(t_reg[l][3], t_reg[l][1]);
            ma_next[l][5] = dif(s_reg[1], t_reg[l][1]);
            mb_next[l][5] = dif(t_reg[l][2], t_reg[l][0]);
            ma_next[l][6] = dif(s_reg[2], t_reg[l][0]);
            mb_next[l][6] = dif(t_reg[l][3], t_reg[l][1]);
            ma_next[l][7] = dif(s_reg[3], t_reg[l][1]);
            mb_next[l][7] = dif(t_reg[l][2], t_reg[l][0]);
        end

        // inclusive point-in-box for either endpoint
        ctl_next.cmd   = cmd_reg;
        ctl_next.share = share_reg;
        ctl_next.inbox =
            (s_reg[0] >= box_reg[0] && s_reg[0] <= box_reg[2] &&
             s_reg[1] >= box_reg[1] && s_reg[1] <= box_reg[3]) ||
            (s_reg[2] >= box_reg[0] && s_reg[2] <= box_reg[2] &&
             s_reg[3] >= box_reg[1] && s_reg[3] <= box_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= ctl_next;
            for (int l = 0; l < sit_pkg::NUM_LANES; l++)
            begin
                ovl_reg[l] <= ovl_next[l];
                for (int k = 0; k < sit_pkg::NUM_PROD; k++)
                begin
                    ma_reg[l][k] <= ma_next[l][k];
                    mb_reg[l][k] <= mb_next[l][k];
                end
            end
        end
    end

    assign ma  = ma_reg;
    assign mb  = mb_reg;
    assign ovl = ovl_reg;
    assign ctl = ctl_reg;

endmodule

// ===== src/sit_lane.sv =====
// ----------------------------------------------------------------------------
// sit_lane
// One segment test lane: eight registered multipliers, then the four cross
// products and their sign tests, giving none, crossing or contact.
// ----------------------------------------------------------------------------
module sit_lane #(
    parameter int W = sit_pkg::COORD_BITS_DEF
) (
    input  logic              clk,
    input  logic              en,
    input  logic signed [W:0] ma [sit_pkg::NUM_PROD],
    input  logic signed [W:0] mb [sit_pkg::NUM_PROD],
    input  logic              ovl,
    output sit_pkg::seg_res_t res
);

    localparam int PW = 2 * W + 2;
    localparam int CW = PW + 1;

    logic signed [PW-1:0] prod_reg [sit_pkg::NUM_PROD];
    logic signed [PW-1:0] prod_next [sit_pkg::NUM_PROD];
    logic                 ovl_reg;
    logic signed [CW-1:0] cr [sit_pkg::NUM_CROSS];
    logic                 pos [sit_pkg::NUM_CROSS];
    logic                 neg [sit_pkg::NUM_CROSS];
    logic                 zro [sit_pkg::NUM_CROSS];
    logic                 z1, z2, rej1, rej2;
    sit_pkg::seg_res_t    res_reg;
    sit_pkg::seg_res_t    res_next;

    // Stage 3: products
    always_comb
    begin
        for (int k = 0; k < sit_pkg::NUM_PROD; k++)
        begin
            prod_next[k] = PW'(ma[k]) * PW'(mb[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovl_reg <= ovl;
            for (int k = 0; k < sit_pkg::NUM_PROD; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
    end

    // Stage 4: cross products and classification
    always_comb
    begin
        for (int j = 0; j < sit_pkg::NUM_CROSS; j++)
        begin
            cr[j]  = $signed({prod_reg[2*j][PW-1], prod_reg[2*j]}) -
                     $signed({prod_reg[2*j+1][PW-1], prod_reg[2*j+1]});
            zro[j] = (cr[j] == '0);
            neg[j] = cr[j][CW-1];
            pos[j] = !cr[j][CW-1] && !zro[j];
        end
        z1   = zro[0] || zro[1];
        z2   = zro[2] || zro[3];
        // both endpoints strictly on one side of the other line
        rej1 = ((pos[0] && pos[1]) || (neg[0] && neg[1])) && !z1;
        rej2 = ((pos[2] && pos[3]) || (neg[2] && neg[3])) && !z2;
        if (!ovl_reg || rej1 || rej2)
        begin
            res_next = sit_pkg::SEG_NONE;
        end
        else if (z1 || z2)
        begin
            res_next = sit_pkg::SEG_CONTACT;
        end
        else
        begin
            res_next = sit_pkg::SEG_CROSS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== src/segment_intersection_test_top.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_test_top
// Integer segment intersection, touch, shared endpoint and segment-box test.
// ----------------------------------------------------------------------------
// Fully pipelined: one item can be accepted every cycle while stall is low,
// and its hit bit is presented from the output register. The four segment
// test lanes run in parallel, each with a registered bank of eight
// (COORD_BITS+1)-bit signed multipliers followed by a registered cross product
// and sign stage. When res_stall holds a waiting result, the whole pipeline
// freezes and stall is raised toward the source; nothing is dropped.
module segment_intersection_test_top #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid,
    output logic                         stall,
    input  logic [1:0]                   command,
    input  logic signed [COORD_BITS-1:0] seg_a_x,
    input  logic signed [COORD_BITS-1:0] seg_a_y,
    input  logic signed [COORD_BITS-1:0] seg_b_x,
    input  logic signed [COORD_BITS-1:0] seg_b_y,
    input  logic signed [COORD_BITS-1:0] other_a_x,
    input  logic signed [COORD_BITS-1:0] other_a_y,
    input  logic signed [COORD_BITS-1:0] other_b_x,
    input  logic signed [COORD_BITS-1:0] other_b_y,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic                         hit
);

    localparam int DEPTH = 4;

    logic                  en;
    logic [DEPTH-1:0]      v_reg;
    logic                  res_valid_reg;
    logic                  hit_reg;
    logic                  hit_next;
    logic signed [COORD_BITS:0] ma [sit_pkg::NUM_LANES][sit_pkg::NUM_PROD];
    logic signed [COORD_BITS:0] mb [sit_pkg::NUM_LANES][sit_pkg::NUM_PROD];
    logic                  ovl [sit_pkg::NUM_LANES];
    sit_pkg::ctl_t         ctl;
    sit_pkg::ctl_t         ctl3_reg;
    sit_pkg::ctl_t         ctl4_reg;
    sit_pkg::seg_res_t     lane_res [sit_pkg::NUM_LANES];

    // Pipeline advances unless a finished item is held at the output
    assign en    = !(res_valid_reg && res_stall);
    assign stall = !en;

    // Valid bits follow the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[DEPTH-2:0], valid};
            res_valid_reg <= v_reg[DEPTH-1];
        end
    end

    sit_front #(
        .W (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .en        (en),
        .command   (command),
        .seg_a_x   (seg_a_x),
        .seg_a_y   (seg_a_y),
        .seg_b_x   (seg_b_x),
        .seg_b_y   (seg_b_y),
        .other_a_x (other_a_x),
        .other_a_y (other_a_y),
        .other_b_x (other_b_x),
        .other_b_y (other_b_y),
        .ma        (ma),
        .mb        (mb),
        .ovl       (ovl),
        .ctl       (ctl)
    );

    for (genvar l = 0; l < sit_pkg::NUM_LANES; l++)
    begin : g_lane
        sit_lane #(
            .W (COORD_BITS)
        ) u_lane (
            .clk (clk),
            .en  (en),
            .ma  (ma[l]),
            .mb  (mb[l]),
            .ovl (ovl[l]),
            .res (lane_res[l])
        );
    end

    // Control rides alongside the lane stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl3_reg <= ctl;
            ctl4_reg <= ctl3_reg;
        end
    end

    // Stage 5: pick the answer for the command
    always_comb
    begin
        case (ctl4_reg.cmd)
            sit_pkg::CMD_INTERSECTS: hit_next = (lane_res[0] != sit_pkg::SEG_NONE);
            sit_pkg::CMD_TOUCHES:    hit_next = (lane_res[0] == sit_pkg::SEG_CONTACT);
            sit_pkg::CMD_SHARES:     hit_next = ctl4_reg.share;
            sit_pkg::CMD_BOX:
            begin
                hit_next = ctl4_reg.inbox ||
                           (lane_res[0] != sit_pkg::SEG_NONE) ||
                           (lane_res[1] != sit_pkg::SEG_NONE) ||
                           (lane_res[2] != sit_pkg::SEG_NONE) ||
                           (lane_res[3] != sit_pkg::SEG_NONE);
            end
            default:                 hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign hit       = hit_reg;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the segment intersection test pipeline.
// A driver feeds queued query items over the valid/stall input channel and a
// monitor checks every hit bit against an in-bench predictor, which uses exact
// integer cross products. Sender gaps and receiver stalls vary by phase, and
// one long receiver hold-off backs up the whole pipeline.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sit_pkg::*;

    localparam int CW        = COORD_BITS_DEF;
    localparam int HOLD_LEN  = 200;
    localparam int TAIL_CYC  = 20;
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

    typedef struct packed {
        cmd_t               cmd;
        logic signed [CW-1:0] sax, say, sbx, sby;
        logic signed [CW-1:0] oax, oay, obx, oby;
    } query_t;

    typedef struct packed {
        query_t q;
        logic   hit;
    } hit_entry_t;

    // DUT connections
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 valid = 1'b0;
    logic                 stall;
    logic [1:0]           command = '0;
    logic signed [CW-1:0] seg_a_x = '0, seg_a_y = '0, seg_b_x = '0, seg_b_y = '0;
    logic signed [CW-1:0] other_a_x = '0, other_a_y = '0, other_b_x = '0, other_b_y = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic                 hit;

    // Bench state
    query_t     queued_queries[$];
    hit_entry_t hit_expected[$];
    query_t     offered;
    hit_entry_t got_entry;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         hold_req = 1'b0;
    int         hold_left = 0;
    int         errors = 0;

    segment_intersection_test_top #(.COORD_BITS(CW)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (valid),
        .stall     (stall),
        .command   (command),
        .seg_a_x   (seg_a_x),
        .seg_a_y   (seg_a_y),
        .seg_b_x   (seg_b_x),
        .seg_b_y   (seg_b_y),
        .other_a_x (other_a_x),
        .other_a_y (other_a_y),
        .other_b_x (other_b_x),
        .other_b_y (other_b_y),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .hit       (hit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint min2(longint p, longint q);
        return (p < q) ? p : q;
    endfunction

    function automatic longint max2(longint p, longint q);
        return (p > q) ? p : q;
    endfunction

    // cross of (p - a) with (b - a)
    function automatic longint cross_at(longint ax, longint ay, longint bx, longint by,
                                        longint px, longint py);
        return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
    endfunction

    function automatic bit strict_same_side(longint u, longint v);
        return (u > 0 && v > 0) || (u < 0 && v < 0);
    endfunction

    function automatic seg_res_t seg_vs_seg(longint sax, longint say, longint sbx,
                                            longint sby, longint tax, longint tay,
                                            longint tbx, longint tby);
        longint c1, c2, c3, c4;
        bit     z1, z2;
        // inclusive bounding-box prefilter
        if (min2(sax, sbx) > max2(tax, tbx) || min2(tax, tbx) > max2(sax, sbx) ||
            min2(say, sby) > max2(tay, tby) || min2(tay, tby) > max2(say, sby))
            return SEG_NONE;
        c1 = cross_at(sax, say, sbx, sby, tax, tay);
        c2 = cross_at(sax, say, sbx, sby, tbx, tby);
        z1 = (c1 == 0) || (c2 == 0);
        if (strict_same_side(c1, c2) && !z1)
            return SEG_NONE;
        c3 = cross_at(tax, tay, tbx, tby, sax, say);
        c4 = cross_at(tax, tay, tbx, tby, sbx, sby);
        z2 = (c3 == 0) || (c4 == 0);
        if (strict_same_side(c3, c4) && !z2)
            return SEG_NONE;
        return (z1 || z2) ? SEG_CONTACT : SEG_CROSS;
    endfunction

    function automatic bit point_in_box(longint x, longint y, longint x0, longint y0,
                                        longint x1, longint y1);
        return x >= x0 && x <= x1 && y >= y0 && y <= y1;
    endfunction

    function automatic logic predict_hit(query_t q);
        longint   sax = $signed(q.sax), say = $signed(q.say);
        longint   sbx = $signed(q.sbx), sby = $signed(q.sby);
        longint   oax = $signed(q.oax), oay = $signed(q.oay);
        longint   obx = $signed(q.obx), oby = $signed(q.oby);
        longint   x0, x1, y0, y1;
        seg_res_t r;
        case (q.cmd)
            CMD_INTERSECTS:
            begin
                r = seg_vs_seg(sax, say, sbx, sby, oax, oay, obx, oby);
                return r != SEG_NONE;
            end
            CMD_TOUCHES:
            begin
                r = seg_vs_seg(sax, say, sbx, sby, oax, oay, obx, oby);
                return r == SEG_CONTACT;
            end
            CMD_SHARES:
                return (sax == oax && say == oay) || (sax == obx && say == oby) ||
                       (sbx == oax && sby == oay) || (sbx == obx && sby == oby);
            default:
            begin
                // box corners in either order
                x0 = min2(oax, obx);
                x1 = max2(oax, obx);
                y0 = min2(oay, oby);
                y1 = max2(oay, oby);
                return point_in_box(sax, say, x0, y0, x1, y1) ||
                       point_in_box(sbx, sby, x0, y0, x1, y1) ||
                       seg_vs_seg(sax, say, sbx, sby, x0, y0, x0, y1) != SEG_NONE ||
                       seg_vs_seg(sax, say, sbx, sby, x0, y0, x1, y0) != SEG_NONE ||
                       seg_vs_seg(sax, say, sbx, sby, x1, y0, x1, y1) != SEG_NONE ||
                       seg_vs_seg(sax, say, sbx, sby, x0, y1, x1, y1) != SEG_NONE;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------
    // span 0 means the full coordinate range
    function automatic logic signed [CW-1:0] rand_coord(int span);
        if (span == 0)
            return CW'($urandom);
        return CW'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic signed [CW-1:0] rand_extreme();
        case ($urandom_range(0, 4))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            3: return '1;
            default: return CW'(1);
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        int     mode, span, dx, dy, n, m;
        q.cmd = cmd_t'($urandom_range(0, 3));
        mode = $urandom_range(0, 9);
        case (mode)
            0, 1:    span = 0;
            2, 3, 4: span = 8;
            8:       span = 1000;
            default: span = 30;
        endcase
        q.sax = rand_coord(span);
        q.say = rand_coord(span);
        q.sbx = rand_coord(span);
        q.sby = rand_coord(span);
        q.oax = rand_coord(span);
        q.oay = rand_coord(span);
        q.obx = rand_coord(span);
        q.oby = rand_coord(span);
        case (mode)
            5:
            begin
                // shared endpoint
                case ($urandom_range(0, 3))
                    0: begin q.oax = q.sax; q.oay = q.say; end
                    1: begin q.obx = q.sax; q.oby = q.say; end
                    2: begin q.oax = q.sbx; q.oay = q.sby; end
                    default: begin q.obx = q.sbx; q.oby = q.sby; end
                endcase
            end
            6:
            begin
                // endpoint exactly on the first segment, sometimes collinear
                dx = int'($urandom_range(0, 10)) - 5;
                dy = int'($urandom_range(0, 10)) - 5;
                n  = $urandom_range(1, 6);
                m  = $urandom_range(0, n);
                q.sbx = CW'(q.sax + n * dx);
                q.sby = CW'(q.say + n * dy);
                q.oax = CW'(q.sax + m * dx);
                q.oay = CW'(q.say + m * dy);
                if ($urandom_range(0, 2) == 0)
                begin
                    m = int'($urandom_range(0, n + 4)) - 2;
                    q.obx = CW'(q.sax + m * dx);
                    q.oby = CW'(q.say + m * dy);
                end
            end
            7:
            begin
                q.sax = rand_extreme();
                q.say = rand_extreme();
                q.sbx = rand_extreme();
                q.sby = rand_extreme();
                q.oax = rand_extreme();
                q.oay = rand_extreme();
                q.obx = rand_extreme();
                q.oby = rand_extreme();
            end
            9:
            begin
                // box query with a segment roaming around it
                q.cmd = CMD_BOX;
                q.sax = rand_coord(60);
                q.say = rand_coord(60);
                q.sbx = rand_coord(60);
                q.sby = rand_coord(60);
            end
            default: ;
        endcase
        return q;
    endfunction

    task automatic queue_query(cmd_t c, int ax, int ay, int bx, int by,
                               int cx, int cy, int ex, int ey);
        query_t q;
        q.cmd = c;
        q.sax = CW'(ax);
        q.say = CW'(ay);
        q.sbx = CW'(bx);
        q.sby = CW'(by);
        q.oax = CW'(cx);
        q.oay = CW'(cy);
        q.obx = CW'(ex);
        q.oby = CW'(ey);
        queued_queries.push_back(q);
    endtask

    task automatic queue_random(int count);
        repeat (count)
            queued_queries.push_back(rand_query());
    endtask

    // Wait until every queued item is accepted and every hit has come back
    task automatic drain();
        while (queued_queries.size() != 0 || valid || hit_expected.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid     <= 1'b0;
            command   <= '0;
            seg_a_x   <= '0;
            seg_a_y   <= '0;
            seg_b_x   <= '0;
            seg_b_y   <= '0;
            other_a_x <= '0;
            other_a_y <= '0;
            other_b_x <= '0;
            other_b_y <= '0;
        end
        else
        begin
            // item taken this edge: record its expected hit
            if (valid && !stall)
                hit_expected.push_back('{q: offered, hit: predict_hit(offered)});
            // a stalled item is held as is
            if (!valid || !stall)
            begin
                if (queued_queries.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered = queued_queries.pop_front();
                    valid     <= 1'b1;
                    command   <= offered.cmd;
                    seg_a_x   <= offered.sax;
                    seg_a_y   <= offered.say;
                    seg_b_x   <= offered.sbx;
                    seg_b_y   <= offered.sby;
                    other_a_x <= offered.oax;
                    other_a_y <= offered.oay;
                    other_b_x <= offered.obx;
                    other_b_y <= offered.oby;
                end
                else
                    valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver hold-off counter
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_LEN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted hit against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (hit_expected.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got hit %0b",
                             $time, hit);
                end
                else
                begin
                    got_entry = hit_expected.pop_front();
                    if (hit !== got_entry.hit)
                    begin
                        errors++;
                        $display("%0t: hit mismatch, expected %0b, actual %0b",
                                 $time, got_entry.hit, hit);
                        $display("    cmd %s (%0d,%0d)-(%0d,%0d) vs (%0d,%0d)-(%0d,%0d)",
                                 got_entry.q.cmd.name(),
                                 $signed(got_entry.q.sax), $signed(got_entry.q.say),
                                 $signed(got_entry.q.sbx), $signed(got_entry.q.sby),
                                 $signed(got_entry.q.oax), $signed(got_entry.q.oay),
                                 $signed(got_entry.q.obx), $signed(got_entry.q.oby));
                    end
                end
            end
            res_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items, no idling
        queue_query(CMD_INTERSECTS, 0, 0, 10, 10, 0, 10, 10, 0);      // proper cross
        queue_query(CMD_TOUCHES, 0, 0, 10, 10, 0, 10, 10, 0);         // cross is no touch
        queue_query(CMD_INTERSECTS, 0, 0, 10, 0, 5, 0, 5, 5);         // T contact
        queue_query(CMD_TOUCHES, 0, 0, 10, 0, 5, 0, 5, 5);
        queue_query(CMD_TOUCHES, 0, 0, 10, 0, 5, 0, 15, 0);           // collinear overlap
        queue_query(CMD_INTERSECTS, 0, 0, 4, 0, 5, 0, 9, 0);          // collinear, apart
        queue_query(CMD_INTERSECTS, 0, 0, 10, 0, 0, 1, 10, 1);        // parallel
        queue_query(CMD_TOUCHES, 3, 3, 3, 3, 0, 0, 6, 6);             // point on segment
        queue_query(CMD_INTERSECTS, 2, 2, 2, 2, 2, 2, 2, 2);          // two equal points
        queue_query(CMD_INTERSECTS, 7, 1, 7, 1, 0, 0, 6, 6);          // point off segment
        queue_query(CMD_SHARES, 1, 2, 3, 4, 3, 4, 9, 9);
        queue_query(CMD_SHARES, 1, 2, 3, 4, 3, 5, 1, 3);
        queue_query(CMD_SHARES, -5, 6, 0, 0, -5, 6, 8, 8);
        queue_query(CMD_BOX, 1, 1, 2, 2, 0, 0, 5, 5);                 // inside box
        queue_query(CMD_BOX, 1, 1, 2, 2, 5, 5, 0, 0);                 // corners reversed
        queue_query(CMD_BOX, -10, 2, 10, 2, 0, 5, 5, 0);              // passes through
        queue_query(CMD_BOX, -10, -10, -5, -5, 0, 0, 5, 5);           // misses
        queue_query(CMD_BOX, 5, 5, 9, 9, 0, 0, 5, 5);                 // on a corner
        queue_query(CMD_BOX, 0, 0, 0, 0, 0, 0, 0, 0);                 // zero-area box
        queue_query(CMD_BOX, 6, 0, 0, 6, 0, 0, 2, 2);                 // diagonal near miss
        queue_query(CMD_INTERSECTS, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN);
        queue_query(CMD_TOUCHES, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN);
        queue_query(CMD_BOX, C_MIN, 0, C_MAX, 0, C_MIN, C_MIN, C_MAX, C_MAX);
        queue_query(CMD_SHARES, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX);
        queue_query(CMD_TOUCHES, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        queue_query(CMD_SHARES, -1, -1, -1, -1, -1, -1, -1, -1);
        drain();

        // random phases; each drain is a sender pause until all hits are back
        queue_random(150);
        drain();

        send_idle_pct = 46;
        queue_random(150);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 46;
        queue_random(150);
        drain();

        send_idle_pct  = 34;
        recv_stall_pct = 34;
        queue_random(150);
        drain();

        // long receiver hold-off while the sender keeps offering items
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random(60);
        hold_req = 1'b1;
        @(negedge clk);
        hold_req = 1'b0;
        while (hold_left != 0)
            @(negedge clk);
        drain();

        repeat (TAIL_CYC) @(negedge clk);
        if (errors == 0 && hit_expected.size() == 0)
            $display("** segment_intersection_test_top: PASSED **");
        else
            $display("** segment_intersection_test_top: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("** segment_intersection_test_top: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
src/sit_pkg.sv
src/sit_front.sv
src/sit_lane.sv
src/segment_intersection_test_top.sv
test/testbench.sv
